@@ design/rgbpwm_pkg.sv @@
// ----------------------------------------------------------------------------
// rgbpwm_pkg
// Shared constants, types and the brightness gain table for the LED encoder.
// ----------------------------------------------------------------------------
package rgbpwm_pkg;

  localparam int unsigned PIXEL_BITS  = 24;
  localparam int unsigned RESET_SLOTS = 50;
  localparam int unsigned MAX_BRIGHT  = 45;
  localparam int unsigned CNT_W       = 6;   // holds up to 63 remaining slots
  localparam int unsigned GAIN_W      = 17;  // unsigned Q16, 1.0 = 65536

  localparam logic [5:0] BRIGHT_RST    = 6'd0;
  localparam logic [7:0] ONE_CODE_RST  = 8'd60;
  localparam logic [7:0] ZERO_CODE_RST = 8'd30;

  typedef enum logic [1:0] {
    REG_BRIGHTNESS = 2'd0,
    REG_ONE_CODE   = 2'd1,
    REG_ZERO_CODE  = 2'd2
  } reg_idx_t;

  // round(tan(b deg) * 65536); input already clamped to 0..45
  function automatic logic [GAIN_W-1:0] tan_gain(input logic [5:0] b);
    logic [GAIN_W-1:0] g;
    case (b)
      6'd0:  g = 17'd0;
      6'd1:  g = 17'd1144;
      6'd2:  g = 17'd2289;
      6'd3:  g = 17'd3435;
      6'd4:  g = 17'd4583;
      6'd5:  g = 17'd5734;
      6'd6:  g = 17'd6888;
      6'd7:  g = 17'd8047;
      6'd8:  g = 17'd9210;
      6'd9:  g = 17'd10380;
      6'd10: g = 17'd11556;
      6'd11: g = 17'd12739;
      6'd12: g = 17'd13930;
      6'd13: g = 17'd15130;
      6'd14: g = 17'd16340;
      6'd15: g = 17'd17560;
      6'd16: g = 17'd18792;
      6'd17: g = 17'd20036;
      6'd18: g = 17'd21294;
      6'd19: g = 17'd22566;
      6'd20: g = 17'd23853;
      6'd21: g = 17'd25157;
      6'd22: g = 17'd26478;
      6'd23: g = 17'd27818;
      6'd24: g = 17'd29179;
      6'd25: g = 17'd30560;
      6'd26: g = 17'd31964;
      6'd27: g = 17'd33392;
      6'd28: g = 17'd34846;
      6'd29: g = 17'd36327;
      6'd30: g = 17'd37837;
      6'd31: g = 17'd39378;
      6'd32: g = 17'd40951;
      6'd33: g = 17'd42560;
      6'd34: g = 17'd44205;
      6'd35: g = 17'd45889;
      6'd36: g = 17'd47615;
      6'd37: g = 17'd49385;
      6'd38: g = 17'd51202;
      6'd39: g = 17'd53070;
      6'd40: g = 17'd54991;
      6'd41: g = 17'd56970;
      6'd42: g = 17'd59009;
      6'd43: g = 17'd61113;
      6'd44: g = 17'd63287;
      default: g = 17'd65536;
    endcase
    return g;
  endfunction

endpackage

@@ design/rgb_led_pwm_bit_encoder.sv @@
// ----------------------------------------------------------------------------
// rgb_led_pwm_bit_encoder
// A pixel item (command 0) becomes 24 duty codes, green, red, blue, MSB first,
// each one_code or zero_code after the channels are scaled by tan(brightness).
// An end-of-frame item (command 1) becomes 50 zero duty codes. The final code
// of each run has out_last set. One duty code leaves per cycle unless
// out_ready stalls the output register. A second item is held in the input
// register while the current one shifts out, and the scaling is done as it
// moves into the shifter, so consecutive items stream with no gap.
// Registers (APB, byte address): 0x0 brightness, 0x4 one_code, 0x8 zero_code.
// ----------------------------------------------------------------------------
module rgb_led_pwm_bit_encoder (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input items
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  // result items
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_duty,
  output logic        out_last
);

  localparam int unsigned PW = rgbpwm_pkg::PIXEL_BITS;
  localparam int unsigned CW = rgbpwm_pkg::CNT_W;

  // configuration registers
  logic [5:0] brightness_r;
  logic [7:0] one_code_r;
  logic [7:0] zero_code_r;
  logic       cfg_wr;
  rgbpwm_pkg::reg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = rgbpwm_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brightness_r <= rgbpwm_pkg::BRIGHT_RST;
      one_code_r   <= rgbpwm_pkg::ONE_CODE_RST;
      zero_code_r  <= rgbpwm_pkg::ZERO_CODE_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        rgbpwm_pkg::REG_BRIGHTNESS: brightness_r <= pwdata[5:0];
        rgbpwm_pkg::REG_ONE_CODE:   one_code_r   <= pwdata[7:0];
        rgbpwm_pkg::REG_ZERO_CODE:  zero_code_r  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      rgbpwm_pkg::REG_BRIGHTNESS: prdata = {26'd0, brightness_r};
      rgbpwm_pkg::REG_ONE_CODE:   prdata = {24'd0, one_code_r};
      rgbpwm_pkg::REG_ZERO_CODE:  prdata = {24'd0, zero_code_r};
      default:                    prdata = 32'd0;
    endcase
  end

  // input holding register
  logic       hold_valid_r;
  logic       hold_cmd_r;
  logic [7:0] hold_red_r;
  logic [7:0] hold_green_r;
  logic [7:0] hold_blue_r;

  // serializer
  logic          sh_valid_r;
  logic          sh_cmd_r;
  logic [PW-1:0] sh_word_r;
  logic [CW-1:0] sh_cnt_r;     // slots remaining after the current one

  // output register
  logic       out_valid_r;
  logic [7:0] out_duty_r;
  logic       out_last_r;

  logic          emit;
  logic          emit_last;
  logic          load;
  logic [PW-1:0] scaled_word;
  logic [7:0]    slot_duty;

  rgbpwm_scale u_scale (
    .brightness (brightness_r),
    .red        (hold_red_r),
    .green      (hold_green_r),
    .blue       (hold_blue_r),
    .word       (scaled_word)
  );

  assign emit      = sh_valid_r & (~out_valid_r | out_ready);
  assign emit_last = emit & (sh_cnt_r == '0);
  assign load      = hold_valid_r & (~sh_valid_r | emit_last);
  assign in_ready  = ~hold_valid_r | load;

  assign slot_duty = sh_cmd_r ? 8'd0 : (sh_word_r[PW-1] ? one_code_r : zero_code_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_valid_r <= 1'b1;
    end else if (load) begin
      hold_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_cmd_r   <= in_command;
      hold_red_r   <= in_red;
      hold_green_r <= in_green;
      hold_blue_r  <= in_blue;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sh_valid_r <= 1'b0;
    end else if (load) begin
      sh_valid_r <= 1'b1;
    end else if (emit_last) begin
      sh_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sh_cmd_r  <= hold_cmd_r;
      sh_word_r <= scaled_word;
      sh_cnt_r  <= hold_cmd_r ? CW'(rgbpwm_pkg::RESET_SLOTS - 1) : CW'(PW - 1);
    end else if (emit) begin
      sh_word_r <= {sh_word_r[PW-2:0], 1'b0};
      sh_cnt_r  <= sh_cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_duty_r <= slot_duty;
      out_last_r <= (sh_cnt_r == '0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_duty  = out_duty_r;
  assign out_last  = out_last_r;

  // a pixel run never counts past its 24 slots
  a_pixel_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (sh_valid_r && !sh_cmd_r) |-> (sh_cnt_r <= CW'(PW - 1)))
    else $error("pixel slot count out of range");

  // the shifter only loads when it is empty or finishing its run
  a_load_safe: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (!sh_valid_r || emit_last))
    else $error("serializer overwritten mid-run");

  // an accepted item is held until it moves into the shifter
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> hold_valid_r)
    else $error("accepted item lost");

  // finishing a run with nothing waiting leaves the shifter idle
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_last && !load) |=> !sh_valid_r)
    else $error("serializer did not drain");

endmodule

@@ design/rgbpwm_scale.sv @@
// ----------------------------------------------------------------------------
// rgbpwm_scale
// Applies the brightness gain to one pixel and packs it green, red, blue.
// ----------------------------------------------------------------------------
module rgbpwm_scale (
  input  logic [5:0]                       brightness,
  input  logic [7:0]                       red,
  input  logic [7:0]                       green,
  input  logic [7:0]                       blue,
  output logic [rgbpwm_pkg::PIXEL_BITS-1:0] word
);

  logic [5:0]                      bright_clamped;
  logic [rgbpwm_pkg::GAIN_W-1:0]   gain;
  logic [rgbpwm_pkg::GAIN_W+7:0]   prod_red;
  logic [rgbpwm_pkg::GAIN_W+7:0]   prod_green;
  logic [rgbpwm_pkg::GAIN_W+7:0]   prod_blue;

  always_comb begin
    bright_clamped = (brightness > 6'(rgbpwm_pkg::MAX_BRIGHT)) ?
                     6'(rgbpwm_pkg::MAX_BRIGHT) : brightness;
  end

  assign gain = rgbpwm_pkg::tan_gain(bright_clamped);

  // product never exceeds the channel, so bits [23:16] hold the whole result
  assign prod_red   = {{rgbpwm_pkg::GAIN_W{1'b0}}, red}   * {8'd0, gain};
  assign prod_green = {{rgbpwm_pkg::GAIN_W{1'b0}}, green} * {8'd0, gain};
  assign prod_blue  = {{rgbpwm_pkg::GAIN_W{1'b0}}, blue}  * {8'd0, gain};

  assign word = {prod_green[23:16], prod_red[23:16], prod_blue[23:16]};

endmodule
